// ===== hdl/hilbert_ssb_frequency_shifter_macros.svh =====
// Assertion macros for the SSB frequency shifter checker.
`ifndef HILBERT_SSB_FREQUENCY_SHIFTER_MACROS_SVH
`define HILBERT_SSB_FREQUENCY_SHIFTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define HFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hfs_pkg.sv =====
// Shared types and constants for the Hilbert SSB frequency shifter.
package hfs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PHASE_W  = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Q30 fixed-point constants used when the tables are built
  localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
  localparam logic        [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic        [63:0] PI_Q30      = 64'd3373259426;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_PHASE_STEP = 1'b0
  } reg_idx_e;

endpackage

// ===== hdl/hfs_cell.sv =====
// One stage of the delay-line ring: holds a sample, takes its neighbor's on enable.
module hfs_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [hfs_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [hfs_pkg::SAMPLE_W-1:0] sample_o
);
  import hfs_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  assign sample_d = en_i ? sample_i : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

// ===== hdl/hilbert_ssb_frequency_shifter.sv =====
// Top level of the Hilbert-transform SSB frequency shifter.
//
// Each request on the sample stream is shifted into a ring of TAPS cells; the ring then
// rotates once around while a single 16x18 multiply-accumulate takes the Hilbert FIR sum
// from the last cell, one tap per clock. The in-phase sample is the centre cell. Sine and
// cosine come from a 2^SINE_TABLE_ADDR_BITS entry ROM with two registered read ports,
// addressed by the top bits of the 32-bit phase accumulator, which then advances by
// phase_step. The output I*cos - Q*sin is rounded and saturated to 16 bits. A request is
// taken only in S_IDLE; the item then passes S_RUN (the MAC walk over the ring), S_MUL and
// S_FIN, where the result is loaded into an output register and sits there until taken;
// it waits in S_FIN only if the previous result is still there.
// The FIR and sine tables are built at elaboration; there is no startup pass.
module hilbert_ssb_frequency_shifter #(
  parameter int TAPS                 = 65,
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hfs_pkg::APB_AW-1:0]          paddr,
  input  logic [hfs_pkg::APB_DW-1:0]          pwdata,
  output logic [hfs_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  // input sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hfs_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] sample_in
  // output sample stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [hfs_pkg::SAMPLE_W-1:0]        m_axis_tdata   // [15:0] sample_out
);
  import hfs_pkg::*;

  localparam int SINE_LEN = 1 << SINE_TABLE_ADDR_BITS;
  localparam int CENTRE   = TAPS / 2;
  localparam int CNT_W    = $clog2(TAPS + 1);
  localparam int IDX_W    = $clog2(TAPS);
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAPS);
  localparam int IC_W     = 2 * SAMPLE_W;
  localparam int AS_W     = ACC_W + SAMPLE_W;
  localparam int MIX_W    = AS_W + 1;
  localparam int HI_W     = MIX_W - 32;

  localparam logic [63:0] WIN_DEN1 = 64'(TAPS - 1);
  localparam logic [63:0] WIN_DEN2 = 64'(2 * (TAPS - 1));

  // ---------------------------------------------------------------------------
  // Elaboration-time table construction
  // ---------------------------------------------------------------------------

  // 12-term Taylor cos/sin of a reduced angle x (Q30), then quadrant mapping
  function automatic logic signed [63:0] cos_quad(logic [63:0] x, logic [1:0] quad);
    logic [63:0]        x2, tc, ts;
    logic signed [63:0] c, s;
    x2 = (x * x) >> 30;
    tc = Q30_ONE;
    ts = x;
    c  = Q30_ONE;
    s  = $signed(x);
    tc = ((tc * x2) >> 30) / 64'd2;   ts = ((ts * x2) >> 30) / 64'd6;
    c  = c - $signed(tc);             s  = s - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd12;  ts = ((ts * x2) >> 30) / 64'd20;
    c  = c + $signed(tc);             s  = s + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd30;  ts = ((ts * x2) >> 30) / 64'd42;
    c  = c - $signed(tc);             s  = s - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd56;  ts = ((ts * x2) >> 30) / 64'd72;
    c  = c + $signed(tc);             s  = s + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd90;  ts = ((ts * x2) >> 30) / 64'd110;
    c  = c - $signed(tc);             s  = s - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd132; ts = ((ts * x2) >> 30) / 64'd156;
    c  = c + $signed(tc);             s  = s + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd182; ts = ((ts * x2) >> 30) / 64'd210;
    c  = c - $signed(tc);             s  = s - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd240; ts = ((ts * x2) >> 30) / 64'd272;
    c  = c + $signed(tc);             s  = s + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd306; ts = ((ts * x2) >> 30) / 64'd342;
    c  = c - $signed(tc);             s  = s - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd380; ts = ((ts * x2) >> 30) / 64'd420;
    c  = c + $signed(tc);             s  = s + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd462; ts = ((ts * x2) >> 30) / 64'd506;
    c  = c - $signed(tc);             s  = s - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd552; ts = ((ts * x2) >> 30) / 64'd600;
    c  = c + $signed(tc);             s  = s + $signed(ts);
    unique case (quad)
      2'd0:    return c;
      2'd1:    return -s;
      2'd2:    return -c;
      default: return s;
    endcase
  endfunction

  // cos(2*pi*num/den) for the window, den being one of the two window periods
  function automatic logic signed [63:0] cos_win(logic [63:0] num, logic full);
    logic [63:0] n, q4, quad, rem, x;
    if (full) begin
      n    = num % WIN_DEN2;
      q4   = n * 64'd4;
      quad = q4 / WIN_DEN2;
      rem  = q4 % WIN_DEN2;
      x    = (PI_HALF_Q30 * rem + WIN_DEN2 / 2) / WIN_DEN2;
    end else begin
      n    = num % WIN_DEN1;
      q4   = n * 64'd4;
      quad = q4 / WIN_DEN1;
      rem  = q4 % WIN_DEN1;
      x    = (PI_HALF_Q30 * rem + WIN_DEN1 / 2) / WIN_DEN1;
    end
    return cos_quad(x, quad[1:0]);
  endfunction

  // Shift-subtract quotient, used only while building the FIR table
  function automatic logic [63:0] quot(logic [63:0] a, logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // FIR taps stored in walk order: entry r belongs to delay-line slot TAPS-1-r
  function automatic logic [TAPS-1:0][COEF_W-1:0] coef_walk_table();
    logic [TAPS-1:0][COEF_W-1:0] t;
    logic signed [63:0]          c1, c2, w, num, v;
    logic [63:0]                 d;
    int                          k, j, m, am;
    t = '0;
    for (int r = 0; r < TAPS; r++) begin
      k = TAPS - 1 - r;
      j = 2 * k + 1 - TAPS;
      m = k - CENTRE;
      v = '0;
      if (m % 2 != 0) begin
        am  = (m < 0) ? -m : m;
        c1  = cos_win(64'(j + 2 * (TAPS - 1)), 1'b1);
        c2  = cos_win(64'(j + (TAPS - 1)), 1'b0);
        w   = 64'sd42 * Q30_ONE + 64'sd50 * c1 + 64'sd8 * c2;
        num = w * 64'sd262144;
        d   = PI_Q30 * 64'(100 * am);
        if (num >= 0) begin
          v = $signed(quot(64'(num) + (d >> 1), d));
        end else begin
          v = -$signed(quot(64'(-num) + (d >> 1), d));
        end
        if (m < 0) begin
          v = -v;
        end
        if (v > 64'sd131071) begin
          v = 64'sd131071;
        end
        if (v < -64'sd131072) begin
          v = -64'sd131072;
        end
      end
      t[r] = COEF_W'(v);
    end
    return t;
  endfunction

  // round(32767*sin(2*pi*a/SINE_LEN)), half away from zero
  function automatic logic [SINE_LEN-1:0][SAMPLE_W-1:0] sine_table();
    logic [SINE_LEN-1:0][SAMPLE_W-1:0] t;
    logic [63:0]                       n, q4, rem, x;
    logic signed [63:0]                c, p;
    t = '0;
    for (int a = 0; a < SINE_LEN; a++) begin
      n   = 64'(a + 3 * (SINE_LEN / 4)) & 64'(SINE_LEN - 1);
      q4  = n << 2;
      rem = q4 & 64'(SINE_LEN - 1);
      x   = (PI_HALF_Q30 * rem + 64'(SINE_LEN / 2)) >> SINE_TABLE_ADDR_BITS;
      c   = cos_quad(x, 2'(q4 >> SINE_TABLE_ADDR_BITS));
      p   = c * 64'sd32767;
      if (p >= 0) begin
        p = (p + 64'sd536870912) >>> 30;
      end else begin
        p = -((-p + 64'sd536870912) >>> 30);
      end
      t[a] = SAMPLE_W'(p);
    end
    return t;
  endfunction

  localparam logic [TAPS-1:0][COEF_W-1:0]       COEF_TAB = coef_walk_table();
  localparam logic [SINE_LEN-1:0][SAMPLE_W-1:0] SINE_ROM = sine_table();

  localparam logic signed [HI_W-1:0] SAT_MAX = HI_W'(32767);
  localparam logic signed [HI_W-1:0] SAT_MIN = HI_W'(-32768);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0] phase_step_q, phase_step_d;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    phase_step_d = phase_step_q;
    prdata       = '0;
    unique case (cfg_idx)
      REG_PHASE_STEP: begin
        prdata = phase_step_q;
        if (cfg_wr) begin
          phase_step_d = pwdata;
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
    end else begin
      phase_step_q <= phase_step_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_MUL,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    m_tvalid_q;
  logic [SAMPLE_W-1:0]     m_tdata_q;
  logic                    s_accept, rot, shift_en, out_load;
  logic signed [SAMPLE_W-1:0] sat;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign rot           = (state_q == S_RUN) && (cnt_q != CNT_W'(TAPS));
  assign shift_en      = s_accept || rot;
  // result waits in S_FIN if the previous one is still in the output register
  assign out_load      = (state_q == S_FIN) && (!m_tvalid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= sat;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            state_q <= S_RUN;
            cnt_q   <= '0;
          end
        end
        S_RUN: begin
          if (cnt_q == CNT_W'(TAPS)) begin
            state_q <= S_MUL;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_MUL: state_q <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // ---------------------------------------------------------------------------
  // Delay-line ring: insert on request, then one full rotation for the MAC
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] chain [TAPS];
  logic signed [SAMPLE_W-1:0] feed;

  assign feed = s_accept ? $signed(s_axis_tdata) : chain[TAPS-1];

  for (genvar g = 0; g < TAPS; g++) begin : g_ring
    logic signed [SAMPLE_W-1:0] link_in;
    if (g == 0) begin : g_head
      assign link_in = feed;
    end else begin : g_link
      assign link_in = chain[g-1];
    end
    hfs_cell u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (shift_en),
      .sample_i (link_in),
      .sample_o (chain[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Phase accumulator and sine ROM
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]              phase_q;
  logic [SINE_TABLE_ADDR_BITS-1:0] sin_idx, cos_idx;
  logic signed [SAMPLE_W-1:0]      sin_q, cos_q;

  assign sin_idx = phase_q[PHASE_W-1 -: SINE_TABLE_ADDR_BITS];
  assign cos_idx = sin_idx + SINE_TABLE_ADDR_BITS'(SINE_LEN / 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (s_accept) begin
      phase_q <= phase_q + phase_step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sin_q <= SINE_ROM[sin_idx];
      cos_q <= SINE_ROM[cos_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // MAC and output mix
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0]   coef_cur;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       pv_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] iv_q;
  logic signed [IC_W-1:0]     ic_q;
  logic signed [AS_W-1:0]     as_q;
  logic signed [MIX_W-1:0]    ic_ext, mix;
  logic signed [HI_W-1:0]     hi;

  assign coef_cur = COEF_TAB[cnt_q[IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= rot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot) begin
      prod_q <= chain[TAPS-1] * coef_cur;
    end
    if (s_accept) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    // ring is still in delay-line order on the first walk cycle
    if (state_q == S_RUN && cnt_q == '0) begin
      iv_q <= chain[CENTRE];
    end
    if (state_q == S_MUL) begin
      ic_q <= iv_q * cos_q;
      as_q <= acc_q * sin_q;
    end
  end

  // floor((I*cos*2^17 - acc*sin + 2^31) / 2^32)
  assign ic_ext = MIX_W'(ic_q);
  assign mix    = (ic_ext <<< 17) - MIX_W'(as_q) + (MIX_W'(1) <<< 31);
  assign hi     = $signed(mix[MIX_W-1:32]);

  always_comb begin
    priority if (hi > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (hi < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = hi[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hdl/hfs_checker.sv =====
// Port-level checker for the SSB frequency shifter, bound to the top level.
`include "hilbert_ssb_frequency_shifter_macros.svh"

module hfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic s_req, m_req, cfg_req, rd_step;

  assign s_req   = s_axis_tvalid && s_axis_tready;
  assign m_req   = m_axis_tvalid && m_axis_tready;
  assign cfg_req = psel && penable && pwrite && pready && !paddr[2];
  assign rd_step = psel && !pwrite && !paddr[2];

  // the block works on one sample at a time
  `HFS_ASSERT_NEXT(a_busy_after_req, s_req, !s_axis_tready, "sample accepted while busy")

  // a result that is not taken stays put
  `HFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "pending result changed")

  // while idle no result is produced, so a taken result leaves the port empty
  `HFS_ASSERT_NEXT(a_no_spurious_out, m_req && s_axis_tready, !m_axis_tvalid,
                   "result appeared without a request")

  // phase_step reads back what was just written
  `HFS_ASSERT_NEXT(a_cfg_readback, cfg_req, !rd_step || prdata == $past(pwdata),
                   "phase_step readback mismatch")

endmodule

bind hilbert_ssb_frequency_shifter hfs_checker u_hfs_checker (.*);

// ===== bench/hilbert_ssb_frequency_shifter_tb.sv =====
// Self-checking bench for the Hilbert SSB frequency shifter: stream stimulus, APB setup, predictor.
module hilbert_ssb_frequency_shifter_tb;
  import hfs_pkg::*;

  localparam int TAPS        = 65;
  localparam int SINE_BITS   = 10;
  localparam int SINE_LEN    = 1 << SINE_BITS;
  localparam int CENTRE      = TAPS / 2;
  localparam int HOLD_CYCLES = 600;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 114;

  localparam longint          ONE_Q30     = 64'sd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          PI_Q30_S    = 64'sd3373259426;

  localparam logic [APB_AW-1:0] STEP_ADDR     = {REG_PHASE_STEP, 2'b00};
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = 3'd4;  // index 1, no register there

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_STEP, ROW_UNMAPPED} row_kind_e;
  typedef enum logic [1:0] {BURST_UNIFORM, BURST_SQUARE, BURST_QUIET, BURST_RAILS} burst_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        typed;
    logic [15:0] want;
  } stim_row_t;

  // With zero phase_step, nothing reaches the centre tap for the first 32 samples: output is 0.
  localparam int N_DIRECTED = 22;
  stim_row_t directed [N_DIRECTED] = '{
    '{ROW_SAMPLE,   32'h0000_8000, 1'b1, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_7FFF, 1'b1, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_FFFF, 1'b1, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_0001, 1'b1, 16'h0000},
    '{ROW_UNMAPPED, 32'h1234_5678, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_4000, 1'b1, 16'h0000},
    '{ROW_STEP,     32'h7FFF_FFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_7FFF, 1'b0, 16'h0000},
    '{ROW_STEP,     32'h8000_0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_7FFF, 1'b0, 16'h0000},
    '{ROW_STEP,     32'hFFFF_FFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_1234, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_EDCC, 1'b0, 16'h0000},
    '{ROW_STEP,     32'h4000_0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_8000, 1'b0, 16'h0000},
    '{ROW_STEP,     32'h0000_0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE,   32'h0000_5A5A, 1'b0, 16'h0000}
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata  = '0;  // [15:0] sample_in
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;        // [15:0] sample_out

  hilbert_ssb_frequency_shifter #(
    .TAPS                 (TAPS),
    .SINE_TABLE_ADDR_BITS (SINE_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor state
  int          coef_tab [TAPS];
  int          sine_tab [SINE_LEN];
  int          taps_q   [TAPS];
  logic [31:0] phase_acc = '0;
  logic [31:0] step_reg  = '0;
  logic [15:0] shifted_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int errors         = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_rail         = 0;
  int n_writes       = 0;

  burst_e      burst_kind = BURST_UNIFORM;
  int          burst_left = 0;
  int          sq_left    = 0;
  bit          sq_high    = 1'b0;
  logic [15:0] rx_want;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // cos(2*pi*num/den) in Q30, quadrant reduced, 12-term Taylor series
  function automatic longint cos_q30(longint unsigned num, longint unsigned den);
    longint unsigned n, q4, quad, rem, x, x2, tc, ts, k;
    longint          c, s;
    n    = num % den;
    q4   = n * 64'd4;
    quad = q4 / den;
    rem  = q4 % den;
    x    = (HALF_PI_Q30 * rem + den / 64'd2) / den;
    x2   = (x * x) >> 30;
    tc   = 64'd1 << 30;
    ts   = x;
    c    = ONE_Q30;
    s    = $signed(x);
    for (k = 1; k <= 12; k++) begin
      tc = ((tc * x2) >> 30) / ((64'd2 * k - 64'd1) * (64'd2 * k));
      ts = ((ts * x2) >> 30) / ((64'd2 * k) * (64'd2 * k + 64'd1));
      if (k[0]) begin
        c -= $signed(tc);
        s -= $signed(ts);
      end else begin
        c += $signed(tc);
        s += $signed(ts);
      end
    end
    case (quad)
      64'd0:   return c;
      64'd1:   return -s;
      64'd2:   return -c;
      default: return s;
    endcase
  endfunction

  function automatic longint div_round(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic void build_tables();
    int     k, m, j;
    longint c1, c2, w, v;
    for (k = 0; k < TAPS; k++) begin
      m = k - CENTRE;
      j = 2 * k + 1 - TAPS;
      coef_tab[k] = 0;
      if (m % 2 != 0) begin
        c1 = cos_q30(64'(j + 2 * (TAPS - 1)), 64'(2 * (TAPS - 1)));
        c2 = cos_q30(64'(j + TAPS - 1), 64'(TAPS - 1));
        w  = 42 * ONE_Q30 + 50 * c1 + 8 * c2;
        v  = div_round(w * 262144, 100 * PI_Q30_S * longint'(m < 0 ? -m : m));
        if (m < 0) v = -v;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        coef_tab[k] = int'(v);
      end
    end
    for (k = 0; k < SINE_LEN; k++) begin
      c1 = cos_q30(64'(k + 3 * (SINE_LEN / 4)), 64'(SINE_LEN));
      sine_tab[k] = int'(div_round(c1 * 32767, ONE_Q30));
    end
  endfunction

  // one sample in, one shifted sample out; advances the delay line and phase
  function automatic logic [15:0] shift_sample(logic [15:0] din);
    longint               acc, iv, cv, sv, v;
    logic [SINE_BITS-1:0] idx, cidx;
    int                   k;
    for (k = TAPS - 1; k > 0; k--) taps_q[k] = taps_q[k-1];
    taps_q[0] = int'($signed(din));
    acc = 0;
    for (k = 0; k < TAPS; k++) acc += longint'(coef_tab[k]) * longint'(taps_q[k]);
    iv   = taps_q[CENTRE];
    idx  = phase_acc[31 -: SINE_BITS];
    cidx = idx + SINE_BITS'(SINE_LEN / 4);
    cv   = sine_tab[cidx];
    sv   = sine_tab[idx];
    v    = iv * cv * 131072 - acc * sv;
    v    = (v + 64'sd2147483648) >>> 32;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    phase_acc += step_reg;
    return v[15:0];
  endfunction

  // bursts of one kind; full-scale square edges passing the centre drive Q past full scale
  function automatic logic [15:0] next_sample();
    int          r;
    logic [15:0] smp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 90);
      r = $urandom_range(99);
      burst_kind = r < 40 ? BURST_UNIFORM : r < 65 ? BURST_SQUARE :
                   r < 85 ? BURST_QUIET : BURST_RAILS;
      sq_left = 0;
    end
    burst_left--;
    case (burst_kind)
      BURST_SQUARE: begin
        if (sq_left == 0) begin
          sq_left = $urandom_range(8, 70);
          sq_high = !sq_high;
        end
        sq_left--;
        smp = sq_high ? 16'h7FFF : 16'h8000;
      end
      BURST_QUIET: begin
        r = $urandom_range(0, 512);
        smp = 16'(r - 256);
      end
      BURST_RAILS: begin
        case ($urandom_range(3))
          0:       smp = 16'h7FFF;
          1:       smp = 16'h8000;
          2:       smp = 16'h0000;
          default: smp = 16'hFFFF;
        endcase
      end
      default: smp = 16'($urandom);
    endcase
    return smp;
  endfunction

  function automatic logic [31:0] pick_step(int ph);
    case (ph)
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      4:       return $urandom_range(1, 50_000_000);
      5:       return -$urandom_range(1, 50_000_000);
      6:       return 32'h4000_0000;
      8:       return 32'hFFFF_FFFF;
      9:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_step_readback();
    logic [31:0] rd;
    apb_access(1'b0, STEP_ADDR, '0, rd);
    if (rd !== step_reg) begin
      errors++;
      $display("%0t: phase_step readback mismatch, expected %h actual %h", $time, step_reg, rd);
    end
  endtask

  // stop offering requests and wait until every expected sample is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (shifted_q.size() != 0);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, addr, data, rd);
    if (addr[2] == REG_PHASE_STEP) step_reg = data;
    n_writes++;
    // the bus goes idle between the write and the read
    @(posedge clk_i);
    check_step_readback();
  endtask

  task automatic send_sample(input logic [15:0] din, input bit typed, input logic [15:0] want);
    logic [15:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = shift_sample(din);
    shifted_q.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // output checker and receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (shifted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample_out %0d", $time, $signed(m_axis_tdata));
      end else begin
        rx_want = shifted_q.pop_front();
        n_checked++;
        if (m_axis_tdata !== rx_want) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d actual %0d",
                   $time, $signed(rx_want), $signed(m_axis_tdata));
        end
        if (m_axis_tdata == 16'h7FFF || m_axis_tdata == 16'h8000) n_rail++;
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int r, ph, i;
    build_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_step_readback();

    for (r = 0; r < N_DIRECTED; r++) begin
      case (directed[r].kind)
        ROW_SAMPLE: send_sample(directed[r].value[15:0], directed[r].typed, directed[r].want);
        ROW_STEP:   write_reg(STEP_ADDR, directed[r].value);
        default:    write_reg(UNMAPPED_ADDR, directed[r].value);
      endcase
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(STEP_ADDR, pick_step(ph));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold while requests keep coming, so the input backs up
        if (ph == 4 && i == 10) hold_seq++;
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_drained();
        send_sample(next_sample(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAPS + 8) @(posedge clk_i);
    $display("Shifted %0d samples (%0d checked) under %0d register writes and four stall mixes.",
             n_sent, n_checked, n_writes);
    $display("%0d outputs landed on a saturation rail.", n_rail);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hfs_pkg.sv
hdl/hfs_cell.sv
hdl/hilbert_ssb_frequency_shifter.sv
hdl/hfs_checker.sv
bench/hilbert_ssb_frequency_shifter_tb.sv
